### src/pst_pkg.sv
// Package for the peer session slot table: sizes, codes, slot entry and result types.
// No dependencies; every module of the block imports it.
`default_nettype none

package pst_pkg;

  // Table geometry
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = 4;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_MAX_SLOTS     = 2'd0;
  localparam logic [1:0]  CFG_TIMEOUT       = 2'd1;
  localparam logic [1:0]  CFG_PING_INTERVAL = 2'd2;
  localparam logic [3:0]  RESET_MAX_SLOTS   = 4'd8;
  localparam logic [31:0] RESET_TIMEOUT     = 32'd15000;
  localparam logic [31:0] RESET_PING        = 32'd2000;

  // Input word modes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_JOIN  = 3'd1;
  localparam logic [2:0] MODE_BYE   = 3'd2;
  localparam logic [2:0] MODE_PING  = 3'd3;
  localparam logic [2:0] MODE_PONG  = 3'd4;
  localparam logic [2:0] MODE_OTHER = 3'd5;

  typedef enum logic [2:0] {
    EV_WELCOME   = 3'd0,
    EV_REFUSED   = 3'd1,
    EV_LOBBY     = 3'd2,
    EV_PONG      = 3'd3,
    EV_RTT       = 3'd4,
    EV_DROP_BYE  = 3'd5,
    EV_DROP_TIME = 3'd6,
    EV_PING_REQ  = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_LOBBY,
    S_DONE
  } state_t;

  // One slot entry as held in the slot memory
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] last_seen;
    logic [31:0] pinged_at;
    logic [31:0] rtt;
  } entry_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   addr;
    entry_t              data;
  } ram_wr_t;

  typedef struct packed {
    event_t              ev;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         value;
    logic [CNT_W-1:0]    count;
  } result_t;

  // Number of slots in use
  function automatic logic [CNT_W-1:0] count_used(input logic [NUM_SLOTS-1:0] used);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      n = n + CNT_W'(used[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### src/pst_slot_ram.sv
// Slot entry memory: one write port, one read port with registered read data.
// Depends on pst_pkg for the entry type and table size.
`default_nettype none

module pst_slot_ram
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire ram_wr_t           wr,
  input  wire logic [SLOT_W-1:0] raddr,
  output entry_t                 q
);

  entry_t mem [NUM_SLOTS];

  // Write the selected entry
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    q <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/pst_out_stage.sv
// Result output stage: holds one pending word so the final word of an item can carry last.
// Depends on pst_pkg for the result type.
`default_nettype none

module pst_out_stage
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_v,
  input  wire result_t           push,
  input  wire logic              flush,
  output logic                   res_strobe,
  output logic [2:0]             event_res,
  output logic [SLOT_W-1:0]      slot,
  output logic [31:0]            value,
  output logic [CNT_W-1:0]       present_count,
  output logic                   last
);

  logic    pend_v;
  result_t pend;

  // Hold the newest word; release the older one when another arrives or at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v     <= 1'b0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= pend_v && (push_v || flush);
      if (push_v) begin
        pend_v <= 1'b1;
      end else if (flush) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      pend <= push;
    end
    if (pend_v && (push_v || flush)) begin
      event_res     <= pend.ev;
      slot          <= pend.slot;
      value         <= pend.value;
      present_count <= pend.count;
      last          <= flush;
    end
  end

endmodule

`default_nettype wire

### src/pst_ctrl.sv
// Sequencer: scans the slot memory one entry a cycle, updating it and emitting result words.
// Depends on pst_pkg; drives pst_slot_ram and pst_out_stage.
`default_nettype none

module pst_ctrl
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2:0]        mode,
  input  wire logic [31:0]       addr_key,
  input  wire logic [15:0]       peer_port,
  input  wire logic [31:0]       now_ms,
  input  wire logic [31:0]       stamp,
  input  wire logic [3:0]        max_slots,
  input  wire logic [31:0]       timeout_ms,
  input  wire logic [31:0]       ping_interval_ms,
  output logic                   busy,
  output logic [SLOT_W-1:0]      raddr,
  input  wire entry_t            q,
  output ram_wr_t                wr,
  output logic                   push_v,
  output result_t                push,
  output logic                   flush
);

  state_t                 state, state_next;
  logic [SLOT_W:0]        ctr;
  logic                   proc_v;
  logic [SLOT_W-1:0]      proc_idx;
  logic [NUM_SLOTS-1:0]   used, used_next;
  logic                   found;
  logic [SLOT_W-1:0]      hit_idx;
  entry_t                 hit_entry;
  logic [2:0]             cur_mode;
  logic [31:0]            cur_addr, cur_now, cur_stamp;
  logic [15:0]            cur_port;

  logic                   scan_hit;
  logic                   scan_end;
  logic [31:0]            age, ping_age, rtt_now;
  logic [3:0]             cap;
  logic                   free_v;
  logic [SLOT_W-1:0]      free_idx;
  logic                   fresh;

  assign busy  = (state != S_IDLE);
  assign raddr = ctr[SLOT_W-1:0];

  assign age      = cur_now - q.last_seen;
  assign ping_age = cur_now - q.pinged_at;
  assign rtt_now  = cur_now - cur_stamp;
  assign scan_hit = proc_v && used[proc_idx] && (q.addr == cur_addr) && (q.port == cur_port);
  assign scan_end = proc_v && (proc_idx == SLOT_W'(NUM_SLOTS - 1));
  assign cap      = (max_slots > 4'(NUM_SLOTS)) ? 4'(NUM_SLOTS) : max_slots;
  assign fresh    = (cur_mode == MODE_JOIN) && !found && free_v;

  // Lowest free slot below capacity
  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used[i] && (4'(i) < cap)) begin
        free_v   = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) begin
          if (cur_mode inside {MODE_JOIN, MODE_BYE, MODE_PING, MODE_PONG, MODE_OTHER}) begin
            state_next = S_ACT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ACT:   state_next = fresh ? S_LOBBY : S_DONE;
      S_LOBBY: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory writes, slot flags and result words
  always_comb begin
    used_next  = used;
    wr         = '0;
    push_v     = 1'b0;
    push       = '0;
    push.ev    = EV_WELCOME;
    flush      = 1'b0;
    case (state)
      S_SCAN: begin
        // Tick: drop silent peers, else request a ping when due
        if (cur_mode == MODE_TICK && proc_v && used[proc_idx]) begin
          if (age > timeout_ms) begin
            used_next[proc_idx] = 1'b0;
            push_v     = 1'b1;
            push.ev    = EV_DROP_TIME;
            push.slot  = proc_idx;
          end else if (ping_age >= ping_interval_ms) begin
            wr.we             = 1'b1;
            wr.addr           = proc_idx;
            wr.data           = q;
            wr.data.pinged_at = cur_now;
            push_v     = 1'b1;
            push.ev    = EV_PING_REQ;
            push.slot  = proc_idx;
            push.value = cur_now;
          end
        end
      end
      S_ACT: begin
        if (found) begin
          // Refresh the known peer, then act on the datagram
          wr.we             = 1'b1;
          wr.addr           = hit_idx;
          wr.data           = hit_entry;
          wr.data.last_seen = cur_now;
          push.slot         = hit_idx;
          case (cur_mode)
            MODE_JOIN: begin
              push_v  = 1'b1;
              push.ev = EV_WELCOME;
            end
            MODE_BYE: begin
              used_next[hit_idx] = 1'b0;
              push_v  = 1'b1;
              push.ev = EV_DROP_BYE;
            end
            MODE_PING: begin
              push_v     = 1'b1;
              push.ev    = EV_PONG;
              push.value = cur_stamp;
            end
            MODE_PONG: begin
              wr.data.rtt = rtt_now;
              push_v      = 1'b1;
              push.ev     = EV_RTT;
              push.value  = rtt_now;
            end
            default: begin
            end
          endcase
        end else if (cur_mode == MODE_JOIN) begin
          push_v = 1'b1;
          if (free_v) begin
            wr.we               = 1'b1;
            wr.addr             = free_idx;
            wr.data.addr        = cur_addr;
            wr.data.port        = cur_port;
            wr.data.last_seen   = cur_now;
            used_next[free_idx] = 1'b1;
            push.ev             = EV_WELCOME;
            push.slot           = free_idx;
          end else begin
            push.ev = EV_REFUSED;
          end
        end
      end
      S_LOBBY: begin
        push_v    = 1'b1;
        push.ev   = EV_LOBBY;
        push.slot = hit_idx;
      end
      S_DONE: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase
    push.count = count_used(used_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ctr    <= '0;
      proc_v <= 1'b0;
      used   <= '0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      used   <= used_next;
      proc_v <= (state == S_SCAN) && !ctr[SLOT_W];
      if (state == S_IDLE) begin
        ctr   <= '0;
        found <= 1'b0;
      end else if (state == S_SCAN && !ctr[SLOT_W]) begin
        ctr <= ctr + 1'b1;
      end
      if (state == S_SCAN && scan_hit && !found) begin
        found <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    proc_idx <= ctr[SLOT_W-1:0];
    if (state == S_IDLE && start) begin
      cur_mode  <= mode;
      cur_addr  <= addr_key;
      cur_port  <= peer_port;
      cur_now   <= now_ms;
      cur_stamp <= stamp;
    end
    if (state == S_SCAN && scan_hit && !found) begin
      hit_idx   <= proc_idx;
      hit_entry <= q;
    end else if (state == S_ACT && fresh) begin
      hit_idx <= free_idx;
    end
  end

endmodule

`default_nettype wire

### src/peer_session_slot_table_top.sv
// Top level of the peer session slot table: configuration registers and wiring.
// Depends on pst_pkg, pst_slot_ram, pst_ctrl and pst_out_stage.
//
//   channel  handshake          payload
//   input    start / busy       mode, addr_key, peer_port, now_ms, stamp
//   result   res_strobe         event_res, slot, value, present_count, last
//   config   cfg_we             cfg_index, cfg_data
//
// The slot memory is read one entry a cycle through its single read port, so busy stays
// high while the scan (S_SCAN) reads every slot; a datagram adds an update state (S_ACT),
// a new peer the lobby state (S_LOBBY) for its lobby word, and every item ends with
// S_DONE, which releases its last word. A word leaves in the cycle after the next word is
// formed or the item closes, never held back.
// Reset restores the register defaults and marks every slot free; memory is not cleared.
`default_nettype none

module peer_session_slot_table_top
  import pst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        mode,
  input  wire logic [31:0]       addr_key,
  input  wire logic [15:0]       peer_port,
  input  wire logic [31:0]       now_ms,
  input  wire logic [31:0]       stamp,
  output logic                   res_strobe,
  output logic [2:0]             event_res,
  output logic [SLOT_W-1:0]      slot,
  output logic [31:0]            value,
  output logic [CNT_W-1:0]       present_count,
  output logic                   last,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  logic [3:0]        max_slots;
  logic [31:0]       timeout_ms;
  logic [31:0]       ping_interval_ms;
  logic [SLOT_W-1:0] raddr;
  entry_t            q;
  ram_wr_t           wr;
  logic              push_v;
  result_t           push;
  logic              flush;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots        <= RESET_MAX_SLOTS;
      timeout_ms       <= RESET_TIMEOUT;
      ping_interval_ms <= RESET_PING;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SLOTS:     max_slots        <= cfg_data[3:0];
        CFG_TIMEOUT:       timeout_ms       <= cfg_data;
        CFG_PING_INTERVAL: ping_interval_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pst_slot_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .q     (q)
  );

  pst_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .mode             (mode),
    .addr_key         (addr_key),
    .peer_port        (peer_port),
    .now_ms           (now_ms),
    .stamp            (stamp),
    .max_slots        (max_slots),
    .timeout_ms       (timeout_ms),
    .ping_interval_ms (ping_interval_ms),
    .busy             (busy),
    .raddr            (raddr),
    .q                (q),
    .wr               (wr),
    .push_v           (push_v),
    .push             (push),
    .flush            (flush)
  );

  pst_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .push_v        (push_v),
    .push          (push),
    .flush         (flush),
    .res_strobe    (res_strobe),
    .event_res     (event_res),
    .slot          (slot),
    .value         (value),
    .present_count (present_count),
    .last          (last)
  );

endmodule

`default_nettype wire

### tb/peer_session_slot_table_top_tb.sv
// Self-checking testbench for peer_session_slot_table_top: directed table, then random phases.
// Depends on pst_pkg and the RTL under src; keeps its own slot-table predictor and word queue.
`default_nettype none

module peer_session_slot_table_top_tb
  import pst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 35;

  typedef struct packed {
    event_t      ev;
    logic [2:0]  slot;
    logic [31:0] value;
    logic [3:0]  count;
    logic        last;
  } session_word_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed row; typed = -1 predicted, 0 no word, 1 the word given here
  typedef struct {
    row_kind_t     kind;
    logic [2:0]    md;
    logic [31:0]   a;
    logic [15:0]   p;
    logic [31:0]   t;
    logic [31:0]   st;
    logic [1:0]    idx;
    int            typed;
    session_word_t word;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  mode;
  logic [31:0] addr_key;
  logic [15:0] peer_port;
  logic [31:0] now_ms;
  logic [31:0] stamp;
  logic        res_strobe;
  logic [2:0]  event_res;
  logic [2:0]  slot;
  logic [31:0] value;
  logic [3:0]  present_count;
  logic        last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Predictor state
  logic [3:0]  cap_reg;
  logic [31:0] timeout_reg;
  logic [31:0] ping_reg;
  logic        tbl_used   [NUM_SLOTS];
  logic [31:0] tbl_addr   [NUM_SLOTS];
  logic [15:0] tbl_port   [NUM_SLOTS];
  logic [31:0] tbl_seen   [NUM_SLOTS];
  logic [31:0] tbl_pinged [NUM_SLOTS];
  logic [31:0] tbl_rtt    [NUM_SLOTS];
  logic        tbl_rtt_ok [NUM_SLOTS];

  session_word_t step_words[$];
  session_word_t pending_words[$];
  int            cur_typed;
  session_word_t cur_word;
  int            err_count = 0;
  int            cycles = 0;

  // Random stimulus: peer pool and wall clock
  logic [31:0] pool_addr [10];
  logic [15:0] pool_port [10];
  logic [31:0] clock_ms;
  plan_row_t   plan[$];

  logic [3:0]  phase_cap  [PHASES] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd8};
  logic [31:0] phase_tmo  [PHASES] = '{32'd15000, 32'd0, 32'hFFFF_FFFF, 32'd500,
                                       32'd1000, 32'd40000};
  logic [31:0] phase_ping [PHASES] = '{32'd2000, 32'd0, 32'hFFFF_FFFF, 32'd100,
                                       32'hFFFF_FFFF, 32'd5000};
  int          phase_idle [PHASES] = '{23, 23, 71, 71, 0, 0};

  peer_session_slot_table_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .addr_key      (addr_key),
    .peer_port     (peer_port),
    .now_ms        (now_ms),
    .stamp         (stamp),
    .res_strobe    (res_strobe),
    .event_res     (event_res),
    .slot          (slot),
    .value         (value),
    .present_count (present_count),
    .last          (last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void clear_entry(int i);
    tbl_used[i]   = 1'b0;
    tbl_addr[i]   = '0;
    tbl_port[i]   = '0;
    tbl_seen[i]   = '0;
    tbl_pinged[i] = '0;
    tbl_rtt[i]    = '0;
    tbl_rtt_ok[i] = 1'b0;
  endfunction

  function automatic logic [3:0] used_count();
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < NUM_SLOTS; i++) n += 4'(tbl_used[i]);
    return n;
  endfunction

  function automatic void emit_word(event_t ev, int idx, logic [31:0] val);
    session_word_t w;
    w.ev    = ev;
    w.slot  = 3'(idx);
    w.value = val;
    w.count = used_count();
    w.last  = 1'b0;
    step_words.push_back(w);
  endfunction

  // Apply one accepted word to the table and collect the words it causes
  function automatic void step_table(logic [2:0] md, logic [31:0] a, logic [15:0] p,
                                     logic [31:0] t, logic [31:0] st);
    int hit;
    int cap;
    bit fresh;
    step_words.delete();
    hit = -1;
    fresh = 1'b0;
    if (md == MODE_TICK) begin
      // scan in slot order: drop silent peers, else request a ping when due
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (tbl_used[i]) begin
          if (32'(t - tbl_seen[i]) > timeout_reg) begin
            clear_entry(i);
            emit_word(EV_DROP_TIME, i, '0);
          end else if (32'(t - tbl_pinged[i]) >= ping_reg) begin
            tbl_pinged[i] = t;
            emit_word(EV_PING_REQ, i, t);
          end
        end
      end
    end else if (md <= MODE_OTHER) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (hit < 0 && tbl_used[i] && tbl_port[i] == p && tbl_addr[i] == a) hit = i;
      end
      if (hit >= 0) tbl_seen[hit] = t;
      if (md == MODE_JOIN) begin
        // take the lowest free slot below the capacity for a new peer
        if (hit < 0) begin
          cap = (cap_reg < NUM_SLOTS) ? int'(cap_reg) : NUM_SLOTS;
          for (int i = 0; i < cap; i++) begin
            if (hit < 0 && !tbl_used[i]) hit = i;
          end
          if (hit >= 0) begin
            clear_entry(hit);
            tbl_used[hit] = 1'b1;
            tbl_addr[hit] = a;
            tbl_port[hit] = p;
            tbl_seen[hit] = t;
            fresh = 1'b1;
          end
        end
        if (hit < 0) begin
          emit_word(EV_REFUSED, 0, '0);
        end else begin
          emit_word(EV_WELCOME, hit, '0);
          if (fresh) emit_word(EV_LOBBY, hit, '0);
        end
      end else if (hit >= 0) begin
        case (md)
          MODE_BYE: begin
            clear_entry(hit);
            emit_word(EV_DROP_BYE, hit, '0);
          end
          MODE_PING: begin
            emit_word(EV_PONG, hit, st);
          end
          MODE_PONG: begin
            tbl_rtt[hit]    = t - st;
            tbl_rtt_ok[hit] = 1'b1;
            emit_word(EV_RTT, hit, tbl_rtt[hit]);
          end
          default: begin
          end
        endcase
      end
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    session_word_t want;
    if (rst) begin
      cap_reg     = RESET_MAX_SLOTS;
      timeout_reg = RESET_TIMEOUT;
      ping_reg    = RESET_PING;
      for (int i = 0; i < NUM_SLOTS; i++) clear_entry(i);
      pending_words.delete();
    end else begin
      // compare each result word against the oldest expectation
      if (res_strobe === 1'b1) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: event %0d slot %0d value 0x%0h", event_res, slot, value);
          err_count++;
        end else begin
          want = pending_words.pop_front();
          check_field("event_res", 32'(want.ev), 32'(event_res));
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("value", want.value, value);
          check_field("present_count", 32'(want.count), 32'(present_count));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      // track register writes
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_MAX_SLOTS:     cap_reg = cfg_data[3:0];
          CFG_TIMEOUT:       timeout_reg = cfg_data;
          CFG_PING_INTERVAL: ping_reg = cfg_data;
          default: begin
          end
        endcase
      end
      // predict on every accepted word
      if (start === 1'b1 && busy === 1'b0) begin
        step_table(mode, addr_key, peer_port, now_ms, stamp);
        if (cur_typed >= 0) begin
          step_words.delete();
          if (cur_typed == 1) step_words.push_back(cur_word);
        end
        foreach (step_words[k]) pending_words.push_back(step_words[k]);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver

  function automatic plan_row_t row_item(logic [2:0] md, logic [31:0] a, logic [15:0] p,
                                         logic [31:0] t, logic [31:0] st);
    plan_row_t r;
    r.kind  = ROW_ITEM;
    r.md    = md;
    r.a     = a;
    r.p     = p;
    r.t     = t;
    r.st    = st;
    r.idx   = '0;
    r.typed = -1;
    r.word  = '0;
    return r;
  endfunction

  function automatic plan_row_t row_none(logic [2:0] md, logic [31:0] a, logic [15:0] p,
                                         logic [31:0] t, logic [31:0] st);
    plan_row_t r;
    r = row_item(md, a, p, t, st);
    r.typed = 0;
    return r;
  endfunction

  function automatic plan_row_t row_one(logic [2:0] md, logic [31:0] a, logic [15:0] p,
                                        logic [31:0] t, logic [31:0] st, event_t ev,
                                        logic [2:0] sl, logic [31:0] val, logic [3:0] cnt);
    plan_row_t r;
    r = row_item(md, a, p, t, st);
    r.typed = 1;
    r.word  = '{ev: ev, slot: sl, value: val, count: cnt, last: 1'b1};
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic [1:0] idx, logic [31:0] data);
    plan_row_t r;
    r = row_item(MODE_TICK, '0, '0, '0, data);
    r.kind = ROW_CFG;
    r.idx  = idx;
    return r;
  endfunction

  // Present one word and hold it until the block takes it
  task automatic send_word(logic [2:0] md, logic [31:0] a, logic [15:0] p, logic [31:0] t,
                           logic [31:0] st, int typed, session_word_t w);
    cur_typed = typed;
    cur_word  = w;
    mode      = md;
    addr_key  = a;
    peer_port = p;
    now_ms    = t;
    stamp     = st;
    start     = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // Hold off until every expected word is out and the block has gone quiet
  task automatic drain();
    start = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mostly well-formed traffic from the peer pool, with some noise
  task automatic send_random();
    int          sel;
    int          pi;
    int          span;
    logic [2:0]  md;
    logic [31:0] a;
    logic [15:0] p;
    logic [31:0] st;
    span = (timeout_reg > 32'd40000) ? 40000 : int'(timeout_reg) + 1;
    sel = $urandom_range(0, 19);
    if (sel < 12) clock_ms += $urandom_range(0, 300);
    else if (sel < 19) clock_ms += $urandom_range(0, span + span / 4);
    else clock_ms = $urandom;
    pi = $urandom_range(0, 9);
    a  = pool_addr[pi];
    p  = pool_port[pi];
    st = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 28) begin
      md = MODE_JOIN;
    end else if (sel < 48) begin
      md = MODE_TICK;
    end else if (sel < 58) begin
      md = MODE_PING;
    end else if (sel < 68) begin
      md = MODE_PONG;
      if (sel < 65) st = clock_ms - $urandom_range(0, 500);
    end else if (sel < 76) begin
      md = MODE_OTHER;
    end else if (sel < 84) begin
      md = MODE_BYE;
    end else if (sel < 92) begin
      md = 3'($urandom_range(MODE_BYE, MODE_OTHER));
      a  = $urandom;
      p  = 16'($urandom);
    end else begin
      md = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      a  = $urandom;
      p  = 16'($urandom);
    end
    send_word(md, a, p, clock_ms, st, -1, '0);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int spin;
    rst       = 1'b1;
    start     = 1'b0;
    mode      = '0;
    addr_key  = '0;
    peer_port = '0;
    now_ms    = '0;
    stamp     = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_typed = -1;
    cur_word  = '0;

    for (int i = 0; i < 10; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = 16'($urandom);
    end
    // same address on two ports, same port on two addresses, both extremes
    pool_addr[1] = pool_addr[0];
    pool_port[3] = pool_port[2];
    pool_addr[8] = '0;
    pool_port[8] = '0;
    pool_addr[9] = '1;
    pool_port[9] = '1;

    // unknown peers, unused modes and an empty tick give nothing
    plan.push_back(row_none(MODE_BYE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'd0));
    plan.push_back(row_none(MODE_PING, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF));
    plan.push_back(row_none(MODE_PONG, 32'd0, 16'd0, 32'hFFFF_FFFF, 32'd0));
    plan.push_back(row_none(MODE_OTHER, 32'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row_none(MODE_UNUSED_LO, 32'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row_none(MODE_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF));
    plan.push_back(row_none(MODE_TICK, 32'd0, 16'd0, 32'd0, 32'd0));
    // new peers at the field extremes, then a rejoin, ping, pong, refresh and two more new peers
    plan.push_back(row_item(MODE_JOIN, 32'd0, 16'd0, 32'd0, 32'd0));
    plan.push_back(row_item(MODE_JOIN, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0));
    plan.push_back(row_one(MODE_JOIN, 32'd0, 16'd0, 32'd5, 32'd0,
                           EV_WELCOME, 3'd0, 32'd0, 4'd2));
    plan.push_back(row_one(MODE_PING, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           EV_PONG, 3'd1, 32'hFFFF_FFFF, 4'd2));
    plan.push_back(row_one(MODE_PONG, 32'd0, 16'd0, 32'd3, 32'd10,
                           EV_RTT, 3'd0, 32'hFFFF_FFF9, 4'd2));
    plan.push_back(row_none(MODE_OTHER, 32'd0, 16'd0, 32'd100, 32'd0));
    plan.push_back(row_item(MODE_JOIN, 32'd0, 16'd1, 32'd100, 32'd0));
    plan.push_back(row_item(MODE_JOIN, 32'd1, 16'd0, 32'd100, 32'd0));
    // tick: nothing due, then pings due, then bye, then timeouts
    plan.push_back(row_item(MODE_TICK, 32'd0, 16'd0, 32'd100, 32'd0));
    plan.push_back(row_item(MODE_TICK, 32'd0, 16'd0, 32'd2100, 32'd0));
    plan.push_back(row_one(MODE_BYE, 32'd1, 16'd0, 32'd2100, 32'd0,
                           EV_DROP_BYE, 3'd3, 32'd0, 4'd3));
    plan.push_back(row_item(MODE_TICK, 32'd0, 16'd0, 32'd20000, 32'd0));
    // zero capacity refuses, capacity one admits one peer
    plan.push_back(row_cfg(CFG_MAX_SLOTS, 32'd0));
    plan.push_back(row_one(MODE_JOIN, 32'h1234_5678, 16'h8000, 32'd20000, 32'd0,
                           EV_REFUSED, 3'd0, 32'd0, 4'd0));
    plan.push_back(row_cfg(CFG_MAX_SLOTS, 32'd1));
    plan.push_back(row_item(MODE_JOIN, 32'hA5A5_A5A5, 16'h5A5A, 32'd20010, 32'd0));
    plan.push_back(row_one(MODE_JOIN, 32'h5A5A_5A5A, 16'hA5A5, 32'd20020, 32'd0,
                           EV_REFUSED, 3'd0, 32'd0, 4'd1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // walk the directed table
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        drain();
        write_reg(plan[k].idx, plan[k].st);
      end else begin
        send_word(plan[k].md, plan[k].a, plan[k].p, plan[k].t, plan[k].st,
                  plan[k].typed, plan[k].word);
      end
    end

    // random phases, each under its own register setting
    clock_ms = 32'd30000;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(CFG_MAX_SLOTS, 32'(phase_cap[ph]));
      write_reg(CFG_TIMEOUT, phase_tmo[ph]);
      write_reg(CFG_PING_INTERVAL, phase_ping[ph]);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (j == PHASE_ITEMS / 2) drain();
        idle_gap(phase_idle[ph]);
        send_random();
      end
    end

    // wait out the tail, then give the verdict
    start = 1'b0;
    spin = 0;
    while (pending_words.size() != 0 && spin < 4000) begin
      @(negedge clk);
      spin++;
    end
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      err_count++;
    end
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/pst_pkg.sv
src/pst_slot_ram.sv
src/pst_out_stage.sv
src/pst_ctrl.sv
src/peer_session_slot_table_top.sv
tb/peer_session_slot_table_top_tb.sv
